@@ rtl/prs_pkg.sv @@
// Shared types, constants and helpers of the packet reorder sequencer.
// Used by every module in the rtl folder; depends on nothing else.
`default_nettype none

package prs_pkg;

    // Fixed field widths of the request and result items.
    localparam int SEQ_FIELD_W  = 24;
    localparam int META_W       = 16;
    localparam int COUNT_W      = 32;

    // Defaults of the top-level parameters.
    localparam int WINDOW_SLOTS_DEF = 64;
    localparam int SEQ_BITS_DEF     = 24;

    // Widest slot index that any legal window size needs (1024 slots).
    localparam int SLOT_MAX_W   = 10;

    // At most this many in-order releases follow one packet.
    localparam int MAX_REL      = 64;
    localparam int NREL_W       = $clog2(MAX_REL + 1);

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    // Result status codes.
    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_OLD_DUP  = 3'd1,
        ST_PEND_DUP = 3'd2,
        ST_BEYOND   = 3'd3,
        ST_CLEARED  = 3'd4
    } t_status;

    // Command codes.
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Class that the front assigns to a request.
    typedef enum logic [1:0] {
        CLS_CLEAR,
        CLS_OLD,
        CLS_BEYOND,
        CLS_WINDOW
    } t_cls;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BS_IDLE,
        BS_UPDATE,
        BS_PROBE,
        BS_RELEASE
    } t_bstate;

    // One request item.
    typedef struct packed {
        logic                   cmd;
        logic [SEQ_FIELD_W-1:0] seq_num;
        logic                   resent_flag;
        logic                   complete_flag;
        logic [META_W-1:0]      meta_length;
    } t_in;

    // One result item.
    typedef struct packed {
        t_status                status;
        logic                   release_valid;
        logic [SEQ_FIELD_W-1:0] released_seq;
        logic [COUNT_W-1:0]     meta_total;
        logic                   message_done;
        logic [COUNT_W-1:0]     dup_count;
        logic [COUNT_W-1:0]     resend_count;
        logic [SEQ_FIELD_W-1:0] max_seq_seen;
        logic                   last;
    } t_res;

    // Classified request that travels through the queue.
    typedef struct packed {
        t_cls                  cls;
        logic [SLOT_MAX_W-1:0] slot;
        t_in                   pkt;
    } t_work;

    // Contents of one window slot in the slot memory.
    typedef struct packed {
        logic              complete;
        logic [META_W-1:0] meta_len;
    } t_slot;

    // Saturating increment of a counter.
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        r = (v == '1) ? v : v + COUNT_W'(1);
        return r;
    endfunction

    // Assemble one result item.
    function automatic t_res make_res(
        input t_status                st,
        input logic                   valid,
        input logic [SEQ_FIELD_W-1:0] rseq,
        input logic [COUNT_W-1:0]     meta,
        input logic                   done,
        input logic [COUNT_W-1:0]     dup,
        input logic [COUNT_W-1:0]     resend,
        input logic [SEQ_FIELD_W-1:0] high,
        input logic                   last
    );
        t_res r;
        r.status        = st;
        r.release_valid = valid;
        r.released_seq  = rseq;
        r.meta_total    = meta;
        r.message_done  = done;
        r.dup_count     = dup;
        r.resend_count  = resend;
        r.max_seq_seen  = high;
        r.last          = last;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/prs_front.sv @@
// Front end of the packet reorder sequencer: takes requests and classifies them.
// Depends on prs_pkg; feeds prs_queue with classified work items.
`default_nettype none

module prs_front #(
    parameter int WINDOW_SLOTS = prs_pkg::WINDOW_SLOTS_DEF,
    parameter int SEQ_BITS     = prs_pkg::SEQ_BITS_DEF
) (
    input  wire logic                            i_start,
    input  wire logic                            i_busy,
    input  wire prs_pkg::t_in                    i_in,
    input  wire logic [SEQ_BITS-1:0]             i_next_expected,
    input  wire logic [$clog2(WINDOW_SLOTS)-1:0] i_head,
    output logic                                 o_push,
    output prs_pkg::t_work                       o_work
);

    localparam int IW = $clog2(WINDOW_SLOTS);
    localparam int SW = SEQ_BITS;
    localparam int CW = ((SW > IW + 1) ? SW : IW + 1) + 1;

    logic [SW-1:0]   seq_m;
    logic [CW-1:0]   offset;
    logic [IW:0]     slot_sum;
    logic [IW:0]     slot_wrap;
    logic [IW-1:0]   slot;
    prs_pkg::t_cls   cls;

    // A request is taken when i_start is high and the block is not busy.
    assign o_push = i_start && !i_busy;

    // Distance from the next expected number and the window slot it maps to.
    always_comb begin
        seq_m     = SW'(i_in.seq_num);
        offset    = CW'(seq_m) - CW'(i_next_expected);
        slot_sum  = (IW + 1)'(i_head) + (IW + 1)'(offset);
        slot_wrap = (slot_sum >= (IW + 1)'(WINDOW_SLOTS))
                    ? slot_sum - (IW + 1)'(WINDOW_SLOTS) : slot_sum;
        slot      = IW'(slot_wrap);
    end

    // Classify against the current window.
    always_comb begin
        if (i_in.cmd == prs_pkg::CMD_CLEAR) begin
            cls = prs_pkg::CLS_CLEAR;
        end else if (seq_m < i_next_expected) begin
            cls = prs_pkg::CLS_OLD;
        end else if (offset >= CW'(WINDOW_SLOTS)) begin
            cls = prs_pkg::CLS_BEYOND;
        end else begin
            cls = prs_pkg::CLS_WINDOW;
        end
    end

    always_comb begin
        o_work.cls  = cls;
        o_work.slot = prs_pkg::SLOT_MAX_W'(slot);
        o_work.pkt  = i_in;
    end

endmodule

`default_nettype wire

@@ rtl/prs_queue.sv @@
// Short FIFO of classified work items between the front and the back.
// Depends on prs_pkg for the item type and depth.
`default_nettype none

module prs_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire prs_pkg::t_work i_data,
    input  wire logic           i_pop,
    output logic                o_valid,
    output prs_pkg::t_work      o_data
);

    prs_pkg::t_work                   r_entry [prs_pkg::QUEUE_DEPTH];
    logic [prs_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [prs_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [prs_pkg::QPTR_W:0]         r_count;
    logic [prs_pkg::QPTR_W-1:0]       n_wr_ptr;
    logic [prs_pkg::QPTR_W-1:0]       n_rd_ptr;
    logic [prs_pkg::QPTR_W:0]         n_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign do_push = i_push && (r_count != (prs_pkg::QPTR_W + 1)'(prs_pkg::QUEUE_DEPTH));
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill-count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == prs_pkg::QPTR_W'(prs_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + prs_pkg::QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == prs_pkg::QPTR_W'(prs_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + prs_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + (prs_pkg::QPTR_W + 1)'(1);
        end else if (!do_push && do_pop) begin
            n_count = r_count - (prs_pkg::QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/prs_back.sv @@
// Back end of the packet reorder sequencer: window state, slot memory and in-order release.
// Depends on prs_pkg; takes classified work items from prs_queue.
`default_nettype none

module prs_back #(
    parameter int WINDOW_SLOTS = prs_pkg::WINDOW_SLOTS_DEF,
    parameter int SEQ_BITS     = prs_pkg::SEQ_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_valid,
    input  wire prs_pkg::t_work             i_q_data,
    output logic                            o_pop,
    output logic                            o_busy,
    output logic [SEQ_BITS-1:0]             o_next_expected,
    output logic [$clog2(WINDOW_SLOTS)-1:0] o_head,
    output logic                            o_res_valid,
    output prs_pkg::t_res                   o_res
);

    localparam int IW = $clog2(WINDOW_SLOTS);
    localparam int SW = SEQ_BITS;
    localparam int FW = prs_pkg::SEQ_FIELD_W;
    localparam int CNT = prs_pkg::COUNT_W;

    // Control and window state.
    prs_pkg::t_bstate            r_state, n_state;
    logic [SW-1:0]               r_ne, n_ne;
    logic [IW-1:0]               r_head, n_head;
    logic [WINDOW_SLOTS-1:0]     r_present, n_present;
    logic [CNT-1:0]              r_meta_sum, n_meta_sum;
    logic [CNT-1:0]              r_dup, n_dup;
    logic [CNT-1:0]              r_resend, n_resend;
    logic [SW-1:0]               r_high, n_high;
    logic                        r_done, n_done;
    logic [prs_pkg::NREL_W-1:0]  r_nrel, n_nrel;
    logic                        r_res_valid, n_res_valid;

    // Payload registers.
    prs_pkg::t_work              r_item, n_item;
    prs_pkg::t_status            r_status, n_status;
    prs_pkg::t_res               r_res, n_res;

    // Slot memory with registered read.
    prs_pkg::t_slot              r_slot_mem [WINDOW_SLOTS];
    prs_pkg::t_slot              r_rd_data;
    logic                        mem_we;
    logic                        mem_re;
    logic [IW-1:0]               rd_addr;
    prs_pkg::t_slot              wr_data;

    // Helper values.
    logic [SW-1:0]               seq_m;
    logic [IW-1:0]               slot;
    logic [CNT:0]                meta_add;
    logic [CNT-1:0]              meta_sat;
    logic [WINDOW_SLOTS-1:0]     present_cleared;
    logic [IW-1:0]               head_next;
    logic                        rel_last;
    logic                        rel_done;

    assign o_busy          = (r_state != prs_pkg::BS_IDLE);
    assign o_next_expected = r_ne;
    assign o_head          = r_head;
    assign o_res_valid     = r_res_valid;
    assign o_res           = r_res;
    assign o_pop           = (r_state == prs_pkg::BS_IDLE) && i_q_valid;

    // Release arithmetic for the slot at the head of the window.
    always_comb begin
        seq_m           = SW'(r_item.pkt.seq_num);
        slot            = IW'(r_item.slot);
        meta_add        = {1'b0, r_meta_sum} + (CNT + 1)'(r_rd_data.meta_len);
        meta_sat        = meta_add[CNT] ? '1 : meta_add[CNT-1:0];
        present_cleared = r_present & ~(WINDOW_SLOTS'(1) << r_head);
        if (r_ne == '1) begin
            head_next = '0;
        end else if (r_head == IW'(WINDOW_SLOTS - 1)) begin
            head_next = '0;
        end else begin
            head_next = r_head + IW'(1);
        end
        rel_last = (r_nrel == prs_pkg::NREL_W'(prs_pkg::MAX_REL - 1))
                   || !present_cleared[head_next];
        rel_done = r_done || r_rd_data.complete;
        wr_data.complete = r_item.pkt.complete_flag;
        wr_data.meta_len = r_item.pkt.meta_length;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prs_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    n_state = prs_pkg::BS_UPDATE;
                end
            end
            prs_pkg::BS_UPDATE: begin
                n_state = (r_item.cls == prs_pkg::CLS_CLEAR)
                          ? prs_pkg::BS_IDLE : prs_pkg::BS_PROBE;
            end
            prs_pkg::BS_PROBE: begin
                n_state = r_present[r_head] ? prs_pkg::BS_RELEASE : prs_pkg::BS_IDLE;
            end
            prs_pkg::BS_RELEASE: begin
                n_state = rel_last ? prs_pkg::BS_IDLE : prs_pkg::BS_RELEASE;
            end
            default: begin
                n_state = prs_pkg::BS_IDLE;
            end
        endcase
    end

    // State updates, memory controls and result assembly.
    always_comb begin
        n_ne        = r_ne;
        n_head      = r_head;
        n_present   = r_present;
        n_meta_sum  = r_meta_sum;
        n_dup       = r_dup;
        n_resend    = r_resend;
        n_high      = r_high;
        n_done      = r_done;
        n_nrel      = r_nrel;
        n_res_valid = 1'b0;
        n_item      = r_item;
        n_status    = r_status;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        rd_addr     = r_head;
        unique case (r_state)
            prs_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    n_item = i_q_data;
                end
            end
            prs_pkg::BS_UPDATE: begin
                n_nrel = '0;
                if (r_item.cls == prs_pkg::CLS_CLEAR) begin
                    // A clear returns the window state and all counters to their reset values.
                    n_ne        = '0;
                    n_head      = '0;
                    n_present   = '0;
                    n_meta_sum  = '0;
                    n_dup       = '0;
                    n_resend    = '0;
                    n_high      = '0;
                    n_done      = 1'b0;
                    n_res_valid = 1'b1;
                    n_res = prs_pkg::make_res(prs_pkg::ST_CLEARED, 1'b0, '0, '0, 1'b0,
                                              '0, '0, '0, 1'b1);
                end else begin
                    // Every packet updates the high mark; a resent packet also the resend count.
                    n_high = (seq_m > r_high) ? seq_m : r_high;
                    if (r_item.pkt.resent_flag) begin
                        n_resend = prs_pkg::sat_inc(r_resend);
                    end
                    case (r_item.cls)
                        prs_pkg::CLS_OLD: begin
                            n_status = prs_pkg::ST_OLD_DUP;
                            n_dup    = prs_pkg::sat_inc(r_dup);
                        end
                        prs_pkg::CLS_BEYOND: begin
                            n_status = prs_pkg::ST_BEYOND;
                        end
                        default: begin
                            if (r_present[slot]) begin
                                n_status = prs_pkg::ST_PEND_DUP;
                            end else begin
                                n_status        = prs_pkg::ST_ACCEPTED;
                                n_present[slot] = 1'b1;
                                mem_we          = 1'b1;
                            end
                        end
                    endcase
                end
            end
            prs_pkg::BS_PROBE: begin
                if (r_present[r_head]) begin
                    mem_re  = 1'b1;
                    rd_addr = r_head;
                end else begin
                    // Nothing to release: one result with the status and counters, no released number.
                    n_res_valid = 1'b1;
                    n_res = prs_pkg::make_res(r_status, 1'b0, '0, r_meta_sum, r_done,
                                              r_dup, r_resend, FW'(r_high), 1'b1);
                end
            end
            prs_pkg::BS_RELEASE: begin
                // Release the head slot and, unless it is the last release, read the following one.
                n_present   = present_cleared;
                n_meta_sum  = meta_sat;
                n_done      = rel_done;
                n_ne        = r_ne + SW'(1);
                n_head      = head_next;
                n_nrel      = r_nrel + prs_pkg::NREL_W'(1);
                n_res_valid = 1'b1;
                n_res = prs_pkg::make_res(r_status, 1'b1, FW'(r_ne), meta_sat, rel_done,
                                          r_dup, r_resend, FW'(r_high), rel_last);
                if (!rel_last) begin
                    mem_re  = 1'b1;
                    rd_addr = head_next;
                end
            end
            default: begin
                n_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prs_pkg::BS_IDLE;
            r_ne        <= '0;
            r_head      <= '0;
            r_present   <= '0;
            r_meta_sum  <= '0;
            r_dup       <= '0;
            r_resend    <= '0;
            r_high      <= '0;
            r_done      <= 1'b0;
            r_nrel      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ne        <= n_ne;
            r_head      <= n_head;
            r_present   <= n_present;
            r_meta_sum  <= n_meta_sum;
            r_dup       <= n_dup;
            r_resend    <= n_resend;
            r_high      <= n_high;
            r_done      <= n_done;
            r_nrel      <= n_nrel;
            r_res_valid <= n_res_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_status <= n_status;
        r_res    <= n_res;
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_mem[slot] <= wr_data;
        end
        if (mem_re) begin
            r_rd_data <= r_slot_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/packet_reorder_sequencer.sv @@
// Packet reorder sequencer: takes one packet request at a time and delivers its
// results in order, one per clock, with no backpressure from the receiver.
// A request is taken when i_start is high and o_busy is low. A packet passes
// the queue and the back-end states idle, update and probe, then releases up to
// 64 in-order packets; a clear passes idle and update only. The back-end
// sequencer walks the window one slot per cycle through a slot memory with a
// registered read port. Each result is shown for exactly one cycle on o_res,
// marked by o_res_valid, and o_res.last marks the final one.
`default_nettype none

module packet_reorder_sequencer #(
    parameter int WINDOW_SLOTS = prs_pkg::WINDOW_SLOTS_DEF,
    parameter int SEQ_BITS     = prs_pkg::SEQ_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire prs_pkg::t_in  i_in,
    output logic               o_busy,
    output logic               o_res_valid,
    output prs_pkg::t_res      o_res
);

    logic                            push;
    prs_pkg::t_work                  push_work;
    logic                            q_valid;
    prs_pkg::t_work                  q_data;
    logic                            pop;
    logic                            back_busy;
    logic [SEQ_BITS-1:0]             next_expected;
    logic [$clog2(WINDOW_SLOTS)-1:0] head;

    // Busy while any request is queued or being carried out.
    assign o_busy = q_valid || back_busy;

    // Front end: accept and classify.
    prs_front #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .SEQ_BITS     (SEQ_BITS)
    ) u_front (
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_in            (i_in),
        .i_next_expected (next_expected),
        .i_head          (head),
        .o_push          (push),
        .o_work          (push_work)
    );

    // Work queue between the two halves.
    prs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_work),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // Back end: window state and in-order release.
    prs_back #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .SEQ_BITS     (SEQ_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_data        (q_data),
        .o_pop           (pop),
        .o_busy          (back_busy),
        .o_next_expected (next_expected),
        .o_head          (head),
        .o_res_valid     (o_res_valid),
        .o_res           (o_res)
    );

endmodule

`default_nettype wire
